>>> src/ovl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ovl_pkg: shared types and constants of the ordered value list
// Opcodes, transfer payloads, the token that walks the cell chain and the
// controller states.
// ----------------------------------------------------------------------------
package ovl_pkg;

  localparam int LIST_DEPTH_DEF = 16;
  localparam int VALUE_W        = 32;
  localparam int COUNT_OUT_W    = 5;

  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_SEARCH = 2'd2;

  typedef struct packed {
    logic [1:0]                opcode;
    logic signed [VALUE_W-1:0] data_value;
  } in_item_t;

  typedef struct packed {
    logic                   found;
    logic                   rejected_full;
    logic [COUNT_OUT_W-1:0] entry_count;
  } out_item_t;

  // Walks the chain one cell per cycle. hit is set once a cell matched;
  // on a delete every cell from the match on pulls its upper neighbor.
  typedef struct packed {
    logic               vld;
    logic               del;
    logic               hit;
    logic [VALUE_W-1:0] value;
  } tok_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DONE
  } ctl_state_t;

endpackage

>>> src/ordered_value_list.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_value_list: bounded ordered list of signed 32-bit values
// Append at the end, delete the oldest equal entry, search for a value.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (item_valid / item_stall / item) carries an opcode and a
//   value. Output channel (result_valid / result_stall / result) returns one
//   result per item: found, rejected_full and the count after the operation.
//   Entries live in a chain of LIST_DEPTH cells, oldest in cell 0.
//   Append writes the cell at the current count directly. Delete and search
//   send a token up the chain, one cell per cycle, and their result is formed
//   once the token leaves the top cell. An unused opcode changes nothing.
//   One item is in work at a time; item_stall is high while it is, so a new
//   input transfer is taken only after the result of the last one has been
//   handed to the output register.
//   A finished result sits in the output register; the next item is taken
//   while it waits. If result_stall holds the register and another result
//   is ready, that result waits in the controller and input stays stalled.
//   Synchronous reset empties the list and drops any result in flight.
// ----------------------------------------------------------------------------
module ordered_value_list #(
  parameter int LIST_DEPTH = ovl_pkg::LIST_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  ovl_pkg::in_item_t item,
  output logic              result_valid,
  input  logic              result_stall,
  output ovl_pkg::out_item_t result
);
  import ovl_pkg::*;

  localparam int CNT_W = $clog2(LIST_DEPTH + 1);

  ctl_state_t       state, state_next;
  logic [CNT_W-1:0] count, count_next;
  out_item_t        pend, pend_next;
  logic             result_load;
  logic             accept;
  logic             full;

  tok_t               tok_chain [LIST_DEPTH+1];
  logic [VALUE_W-1:0] cell_value [LIST_DEPTH];
  logic               cell_valid [LIST_DEPTH];

  assign item_stall = (state != ST_IDLE);
  assign accept     = item_valid && !item_stall;
  assign full       = (count == CNT_W'(LIST_DEPTH));

  // Launch a token into cell 0 on a delete or search transfer.
  always_comb begin
    tok_chain[0].vld   = accept && ((item.opcode == OP_DELETE) ||
                                    (item.opcode == OP_SEARCH));
    tok_chain[0].del   = (item.opcode == OP_DELETE);
    tok_chain[0].hit   = 1'b0;
    tok_chain[0].value = item.data_value;
  end

  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    logic [VALUE_W-1:0] nb_value;
    logic               nb_valid;
    logic               wr_en;

    if (i == LIST_DEPTH - 1) begin : g_top
      assign nb_value = '0;
      assign nb_valid = 1'b0;
    end else begin : g_mid
      assign nb_value = cell_value[i+1];
      assign nb_valid = cell_valid[i+1];
    end

    assign wr_en = accept && (item.opcode == OP_APPEND) && (count == CNT_W'(i));

    ovl_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .tok_in   (tok_chain[i]),
      .nb_value (nb_value),
      .nb_valid (nb_valid),
      .wr_en    (wr_en),
      .wr_value (item.data_value),
      .tok_out  (tok_chain[i+1]),
      .value    (cell_value[i]),
      .valid    (cell_valid[i])
    );
  end

  always_comb begin
    state_next  = state;
    count_next  = count;
    pend_next   = pend;
    result_load = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (item.opcode) inside
            OP_APPEND: begin
              if (full) begin
                pend_next = '{found: 1'b0, rejected_full: 1'b1,
                              entry_count: COUNT_OUT_W'(count)};
              end else begin
                count_next = count + CNT_W'(1);
                pend_next  = '{found: 1'b0, rejected_full: 1'b0,
                               entry_count: COUNT_OUT_W'(count_next)};
              end
              state_next = ST_DONE;
            end
            OP_DELETE, OP_SEARCH: begin
              state_next = ST_WALK;
            end
            default: begin
              pend_next  = '{found: 1'b0, rejected_full: 1'b0,
                             entry_count: COUNT_OUT_W'(count)};
              state_next = ST_DONE;
            end
          endcase
        end
      end
      ST_WALK: begin
        if (tok_chain[LIST_DEPTH].vld) begin
          if (tok_chain[LIST_DEPTH].del && tok_chain[LIST_DEPTH].hit) begin
            count_next = count - CNT_W'(1);
          end
          pend_next  = '{found: tok_chain[LIST_DEPTH].hit, rejected_full: 1'b0,
                         entry_count: COUNT_OUT_W'(count_next)};
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        // Hand the result over once the output register is free.
        if (!result_valid || !result_stall) begin
          result_load = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      count        <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      count        <= count_next;
      result_valid <= result_load | (result_valid & result_stall);
    end
  end

  always_ff @(posedge clk) begin
    pend <= pend_next;
    if (result_load) begin
      result <= pend;
    end
  end

endmodule

>>> src/ovl_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ovl_cell: one slot of the ordered value list
// Holds one value and its valid bit, compares against the passing token and
// shifts in its upper neighbor when a delete has matched at or below it.
// ----------------------------------------------------------------------------
module ovl_cell (
  input  logic                         clk,
  input  logic                         rst,
  input  ovl_pkg::tok_t                tok_in,
  input  logic [ovl_pkg::VALUE_W-1:0]  nb_value,
  input  logic                         nb_valid,
  input  logic                         wr_en,
  input  logic [ovl_pkg::VALUE_W-1:0]  wr_value,
  output ovl_pkg::tok_t                tok_out,
  output logic [ovl_pkg::VALUE_W-1:0]  value,
  output logic                         valid
);
  import ovl_pkg::*;

  logic hit_here;
  logic shift;

  assign hit_here = tok_in.vld && !tok_in.hit && valid && (value == tok_in.value);
  assign shift    = tok_in.vld && tok_in.del && (tok_in.hit || hit_here);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= 1'b0;
      tok_out <= '0;
    end else begin
      if (wr_en) begin
        valid <= 1'b1;
      end else if (shift) begin
        valid <= nb_valid;
      end
      tok_out.vld   <= tok_in.vld;
      tok_out.del   <= tok_in.del;
      tok_out.hit   <= tok_in.hit | hit_here;
      tok_out.value <= tok_in.value;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      value <= wr_value;
    end else if (shift) begin
      value <= nb_value;
    end
  end

endmodule

>>> src/ovl_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ovl_checker: port-level checks for the ordered value list
// Watches both channels of the top level; attached by bind.
// ----------------------------------------------------------------------------
module ovl_checker #(
  parameter int LIST_DEPTH = ovl_pkg::LIST_DEPTH_DEF
) (
  input logic               clk,
  input logic               rst,
  input logic               item_valid,
  input logic               item_stall,
  input ovl_pkg::in_item_t  item,
  input logic               result_valid,
  input logic               result_stall,
  input ovl_pkg::out_item_t result
);
  import ovl_pkg::*;

  // Hold a stalled result.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed or dropped");

  // One item at a time: busy right after a transfer.
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> item_stall)
    else $error("input not stalled after a transfer");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(result.found && result.rejected_full))
    else $error("found and rejected_full both set");

  a_reject_at_full: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.rejected_full |->
      result.entry_count == COUNT_OUT_W'(LIST_DEPTH))
    else $error("rejected append with list not full");

endmodule

bind ordered_value_list ovl_checker #(.LIST_DEPTH(LIST_DEPTH)) u_ovl_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .item         (item),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);
